// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

  // Command codes carried on in_mode
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Control characters handled in put mode
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NL        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_PRINT_MIN = 8'h20;

  // Blank cell: space with the fixed attribute
  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam logic [7:0]  ATTR_RESET = 8'h0F;

  // Tab stops sit on multiples of this
  localparam int TAB_STEP = 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_BLANK
  } state_t;

endpackage

// ===== rtl/core/text_console_writer.sv =====
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_mode, in_char_code, in_cell_address
// out     | output    | out_valid, out_ready, out_cell_value, out_cursor_row, out_cursor_col
// cfg     | input     | cfg_valid, cfg_ready, cfg_attribute
//
// Put character, clear and unused mode load the result register when the item is accepted.
// Read cell does one memory read with registered data, then loads the result register.
// A scroll walks the cell memory once, copying each cell one row up, then blanks the
// bottom row; clear blanks every cell. Both go through the single write port.
// After reset a clearing pass blanks the memory; no item is taken.
// The result sits in an output register; a new item is taken once it is free or leaving.
module text_console_writer #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_cell_value,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_attribute
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);

  localparam logic [CNT_W-1:0] CNT_END    = CNT_W'(CELL_COUNT);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_COLS   = CNT_W'(SCREEN_COLUMNS);
  localparam logic [CNT_W-1:0] CNT_BOTTOM = CNT_W'(CELL_COUNT - SCREEN_COLUMNS);
  localparam logic [COL_W:0]   COL_END    = (COL_W+1)'(SCREEN_COLUMNS);
  localparam logic [COL_W:0]   TAB_ADD    = (COL_W+1)'(tcw_pkg::TAB_STEP);
  localparam logic [COL_W:0]   TAB_MASK   = ~((COL_W+1)'(tcw_pkg::TAB_STEP - 1));
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(SCREEN_ROWS - 1);

  // Cell memory
  logic [15:0] mem [CELL_COUNT];

  tcw_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [7:0]        attr_r;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_value_r, out_value_nxt;
  logic [4:0]        out_row_r, out_row_nxt;
  logic [6:0]        out_col_r, out_col_nxt;
  logic              copy_pend_r, copy_pend_nxt;
  logic [ADDR_W-1:0] copy_addr_r;
  logic [15:0]       rd_data_r;
  logic              rd_hit_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic              in_fire;
  logic              out_free;
  logic              addr_in_range;

  // Put-character decode
  logic [COL_W:0]    col_ext;
  logic [COL_W:0]    col_inc;
  logic [COL_W:0]    col_tab;
  logic [COL_W-1:0]  put_col;
  logic              put_nl;
  logic              put_we;
  logic [15:0]       put_data;
  logic [COL_W-1:0]  put_wcol;
  logic [ADDR_W-1:0] put_addr;
  logic [ROW_W-1:0]  put_row;
  logic              put_scroll;

  assign out_free      = !out_valid_r || out_ready;
  assign in_ready      = (state_r == tcw_pkg::S_IDLE) && out_free;
  assign in_fire       = in_valid && in_ready;
  assign cfg_ready     = 1'b1;
  assign addr_in_range = 32'(in_cell_address) < 32'(CELL_COUNT);

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

  // Cursor movement and cell write for one character
  always_comb begin
    col_ext  = {1'b0, col_r};
    col_inc  = col_ext + (COL_W+1)'(1);
    col_tab  = (col_ext + TAB_ADD) & TAB_MASK;
    put_col  = col_r;
    put_nl   = 1'b0;
    put_we   = 1'b0;
    put_data = tcw_pkg::BLANK_CELL;
    put_wcol = col_r;
    case (in_char_code)
      tcw_pkg::CH_NL: begin
        put_nl = 1'b1;
      end
      tcw_pkg::CH_CR: begin
        put_col = '0;
      end
      tcw_pkg::CH_TAB: begin
        if (col_tab >= COL_END) begin
          put_nl = 1'b1;
        end else begin
          put_col = col_tab[COL_W-1:0];
        end
      end
      tcw_pkg::CH_BS: begin
        if (col_r != '0) begin
          put_col  = col_r - COL_W'(1);
          put_wcol = col_r - COL_W'(1);
          put_we   = 1'b1;
        end
      end
      default: begin
        if (in_char_code >= tcw_pkg::CH_PRINT_MIN) begin
          put_we   = 1'b1;
          put_data = {attr_r, in_char_code};
          if (col_inc == COL_END) begin
            put_nl = 1'b1;
          end else begin
            put_col = col_inc[COL_W-1:0];
          end
        end
      end
    endcase
    if (put_nl) begin
      put_col = '0;
    end
    put_scroll = put_nl && (row_r == ROW_LAST);
    put_row    = (put_nl && !put_scroll) ? row_r + ROW_W'(1) : row_r;
    put_addr   = ADDR_W'(CNT_W'(row_r) * CNT_COLS + CNT_W'(put_wcol));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            tcw_pkg::MODE_PUT:   state_nxt = put_scroll ? tcw_pkg::S_SCROLL : tcw_pkg::S_IDLE;
            tcw_pkg::MODE_CLEAR: state_nxt = tcw_pkg::S_BLANK;
            tcw_pkg::MODE_READ:  state_nxt = tcw_pkg::S_READ;
            default:             state_nxt = tcw_pkg::S_IDLE;
          endcase
        end
      end
      tcw_pkg::S_READ: begin
        state_nxt = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_SCROLL: begin
        if (scan_r == CNT_END) begin
          state_nxt = tcw_pkg::S_BLANK;
        end
      end
      tcw_pkg::S_BLANK: begin
        if (scan_r == CNT_LAST) begin
          state_nxt = tcw_pkg::S_IDLE;
        end
      end
      default: state_nxt = tcw_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory ports and result register
  always_comb begin
    scan_nxt      = scan_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    copy_pend_nxt = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = put_addr;
    mem_wdata     = put_data;
    mem_re        = 1'b0;
    mem_raddr     = ADDR_W'(in_cell_address);
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    case (state_r)
      tcw_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            tcw_pkg::MODE_PUT: begin
              mem_we   = put_we;
              row_nxt  = put_row;
              col_nxt  = put_col;
              scan_nxt = CNT_COLS;
            end
            tcw_pkg::MODE_CLEAR: begin
              row_nxt  = '0;
              col_nxt  = '0;
              scan_nxt = '0;
            end
            tcw_pkg::MODE_READ: begin
              mem_re = 1'b1;
            end
            default: begin
            end
          endcase
          // Result known now for every mode but read
          if (in_mode != tcw_pkg::MODE_READ) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_row_nxt   = 5'(row_nxt);
            out_col_nxt   = 7'(col_nxt);
          end
        end
      end
      tcw_pkg::S_READ: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_hit_r ? rd_data_r : '0;
        out_row_nxt   = 5'(row_r);
        out_col_nxt   = 7'(col_r);
      end
      tcw_pkg::S_SCROLL: begin
        // Read one row below, write it back one row up on the next cycle
        mem_raddr = ADDR_W'(scan_r);
        mem_we    = copy_pend_r;
        mem_waddr = copy_addr_r;
        mem_wdata = rd_data_r;
        if (scan_r != CNT_END) begin
          mem_re        = 1'b1;
          copy_pend_nxt = 1'b1;
          scan_nxt      = scan_r + CNT_W'(1);
        end else begin
          scan_nxt = CNT_BOTTOM;
        end
      end
      tcw_pkg::S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(scan_r);
        mem_wdata = tcw_pkg::BLANK_CELL;
        scan_nxt  = scan_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::S_BLANK;
      scan_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= tcw_pkg::ATTR_RESET;
      out_valid_r <= 1'b0;
      copy_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      copy_pend_r <= copy_pend_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_attribute;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    copy_addr_r <= ADDR_W'(scan_r - CNT_COLS);
    if (in_fire) begin
      rd_hit_r <= addr_in_range;
    end
  end

  // Cell memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // No result is overwritten while it waits
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while result register is held");

  // A read always yields a result on the following cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::S_READ) |=> out_valid_r)
    else $error("read cell did not load the result register");

  // Cursor stays on the screen
  assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < 32'(SCREEN_ROWS)) && (32'(col_r) < 32'(SCREEN_COLUMNS)))
    else $error("cursor off screen");

  // Copy writes happen only during a scroll
  assert property (@(posedge clk) disable iff (!rst_n)
    copy_pend_r |-> (state_r == tcw_pkg::S_SCROLL))
    else $error("pending copy outside scroll");

  // A clear command starts blanking from the first cell
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_mode == tcw_pkg::MODE_CLEAR))
      |=> ((state_r == tcw_pkg::S_BLANK) && (scan_r == '0)))
    else $error("clear did not start the blanking pass");

endmodule
